// ===== src/adsr_pkg.sv =====
// Shared types and constants for the ADSR envelope generator with LFO ramp.
// Used by the configuration register file, the envelope core and the top level.
package adsr_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned StepW   = 7;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned RampW   = 8;
  localparam int unsigned PhaseW  = 12;
  localparam int unsigned OutW    = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 15;

  localparam logic [LevelW-1:0] LevelMax  = 15'd32767;
  localparam logic [PhaseW-1:0] PhaseWrap = 12'd2550;
  localparam logic [OutW-1:0]   EnvMax    = 8'd255;

  // level / 100 == (level * 5243) >> 19, exact for every 15-bit level
  localparam logic [12:0] EnvRecip  = 13'd5243;
  localparam int unsigned EnvShift  = 19;
  // phase / 10 == (phase * 6554) >> 16, exact for every 12-bit phase
  localparam logic [12:0] RampRecip = 13'd6554;
  localparam int unsigned RampShift = 16;

  typedef enum logic [1:0] {
    StageAttack  = 2'd0,
    StageDecay   = 2'd1,
    StageSustain = 2'd2,
    StageRelease = 2'd3
  } stage_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGateThreshold = 3'd0,
    CfgAttackStep    = 3'd1,
    CfgPeakLevel     = 3'd2,
    CfgDecayStep     = 3'd3,
    CfgSustainLevel  = 3'd4,
    CfgReleaseStep   = 3'd5,
    CfgRampStep      = 3'd6,
    CfgUnused        = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] gate_threshold;
    logic [StepW-1:0]   attack_step;
    logic [LevelW-1:0]  peak_level;
    logic [StepW-1:0]   decay_step;
    logic [LevelW-1:0]  sustain_level;
    logic [StepW-1:0]   release_step;
    logic [RampW-1:0]   ramp_step;
  } cfg_t;

endpackage

// ===== src/adsr_envelope_with_lfo_ramp.sv =====
// ADSR envelope generator with a sawtooth LFO ramp, stream in and stream out.
// An item passes through an input register, one update of the envelope state
// and a result register; one item is accepted every cycle as long as results
// are taken.
// Each input item gives exactly one result item. Write configuration only
// while no item is in flight. Depends on adsr_pkg, adsr_cfg and adsr_core.
module adsr_envelope_with_lfo_ramp
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [11:0] gate_sample, [15:12] zero
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata   // [7:0] envelope_value, [15:8] ramp_value
);

  cfg_t               cfg;
  logic               in_valid_q;
  logic [SampleW-1:0] sample_q;
  logic               out_valid_q;
  logic [OutW-1:0]    env_q, ramp_q, env, ramp;
  logic               advance;

  adsr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // move the held item into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  adsr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .sample_i (sample_q),
    .env_o    (env),
    .ramp_o   (ramp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) sample_q <= s_axis_tdata[SampleW-1:0];
    if (advance) begin
      env_q  <= env;
      ramp_q <= ramp;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {ramp_q, env_q};

endmodule

// ===== src/adsr_cfg.sv =====
// Configuration register file for the ADSR envelope generator.
// Depends on adsr_pkg for the register index codes and the cfg_t bundle.
module adsr_cfg
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgGateThreshold: cfg_d.gate_threshold = cfg_data_i[SampleW-1:0];
        CfgAttackStep:    cfg_d.attack_step    = cfg_data_i[StepW-1:0];
        CfgPeakLevel:     cfg_d.peak_level     = cfg_data_i[LevelW-1:0];
        CfgDecayStep:     cfg_d.decay_step     = cfg_data_i[StepW-1:0];
        CfgSustainLevel:  cfg_d.sustain_level  = cfg_data_i[LevelW-1:0];
        CfgReleaseStep:   cfg_d.release_step   = cfg_data_i[StepW-1:0];
        CfgRampStep:      cfg_d.ramp_step      = cfg_data_i[RampW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gate_threshold <= 12'd100;
      cfg_q.attack_step    <= 7'd10;
      cfg_q.peak_level     <= 15'd22000;
      cfg_q.decay_step     <= 7'd10;
      cfg_q.sustain_level  <= 15'd20000;
      cfg_q.release_step   <= 7'd2;
      cfg_q.ramp_step      <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/adsr_core.sv =====
// Envelope and ramp state with the per-tick update and output scaling.
// Depends on adsr_pkg; the state advances only on step_i.
module adsr_core
  import adsr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               step_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [OutW-1:0]    env_o,
  output logic [OutW-1:0]    ramp_o
);

  stage_e            stage_q, stage_d, stage_gated;
  logic [LevelW-1:0] level_q, level_d;
  logic [PhaseW-1:0] phase_q, phase_d, phase_sum;
  logic [LevelW:0]   level_rise;
  logic [LevelW-1:0] level_sat;
  logic              gate_on;
  logic [27:0]       env_prod;
  logic [24:0]       ramp_prod;
  logic [8:0]        env_quot;

  assign gate_on = sample_i > cfg_i.gate_threshold;

  always_comb begin
    phase_sum = phase_q + PhaseW'(cfg_i.ramp_step);
    phase_d   = (phase_sum >= PhaseWrap) ? phase_sum - PhaseWrap : phase_sum;
  end

  always_comb begin
    if (!gate_on) begin
      stage_gated = StageRelease;
    end else if (stage_q == StageRelease) begin
      stage_gated = StageAttack;
    end else begin
      stage_gated = stage_q;
    end

    level_rise = {1'b0, level_q} + (LevelW+1)'(cfg_i.attack_step);
    level_sat  = level_rise[LevelW] ? LevelMax : level_rise[LevelW-1:0];

    stage_d = stage_gated;
    unique case (stage_gated)
      StageAttack: begin
        level_d = level_sat;
        if (level_sat > cfg_i.peak_level) stage_d = StageDecay;
      end
      StageDecay: begin
        level_d = (level_q > LevelW'(cfg_i.decay_step)) ?
                  level_q - LevelW'(cfg_i.decay_step) : '0;
        if (level_d < cfg_i.sustain_level) stage_d = StageSustain;
      end
      StageSustain: begin
        level_d = cfg_i.sustain_level;
      end
      StageRelease: begin
        level_d = (level_q > LevelW'(cfg_i.release_step)) ?
                  level_q - LevelW'(cfg_i.release_step) : '0;
      end
      default: begin
        level_d = level_q;
      end
    endcase
  end

  // divide by constant through reciprocal multiply
  assign env_prod  = 28'(level_d) * 28'(EnvRecip);
  assign env_quot  = env_prod[EnvShift +: 9];
  assign env_o     = (env_quot > 9'(EnvMax)) ? EnvMax : env_quot[OutW-1:0];
  assign ramp_prod = 25'(phase_d) * 25'(RampRecip);
  assign ramp_o    = ramp_prod[RampShift +: OutW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= StageAttack;
      level_q <= '0;
      phase_q <= '0;
    end else if (step_i) begin
      stage_q <= stage_d;
      level_q <= level_d;
      phase_q <= phase_d;
    end
  end

endmodule
